@@ rtl/core/kplc_pkg.sv @@
// ----------------------------------------------------------------------------
// kplc_pkg
// Shared types and constants for the keypad PIN lock controller.
// ----------------------------------------------------------------------------
package kplc_pkg;

    localparam int PIN_SLOTS    = 3;
    localparam int MAX_PIN_KEYS = 5;
    localparam int ENTRY_W      = 4 * MAX_PIN_KEYS;
    localparam int SCNT_W       = $clog2(PIN_SLOTS + 1);

    localparam logic [7:0] ECNT_MAX = 8'd255;
    localparam logic [7:0] UCNT_MAX = 8'd255;
    localparam logic [4:0] HCNT_MAX = 5'd31;

    // key codes, row-major keypad index
    localparam logic [3:0] KEY_ADD  = 4'd3;
    localparam logic [3:0] KEY_HASH = 4'd14;

    // screen codes
    localparam logic [2:0] SCR_HOME      = 3'd0;
    localparam logic [2:0] SCR_ENTER     = 3'd1;
    localparam logic [2:0] SCR_UNLOCKED  = 3'd2;
    localparam logic [2:0] SCR_INCORRECT = 3'd3;
    localparam logic [2:0] SCR_MAX_PINS  = 3'd4;
    localparam logic [2:0] SCR_ADD       = 3'd5;
    localparam logic [2:0] SCR_SAVED     = 3'd6;
    localparam logic [2:0] SCR_RESET     = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_PIN_LENGTH    = 2'd0;
    localparam logic [1:0] CFG_DISPLAY_TICKS = 2'd1;
    localparam logic [1:0] CFG_UNLOCK_TICKS  = 2'd2;
    localparam logic [1:0] CFG_HOLD_TICKS    = 2'd3;

    typedef enum logic [1:0] {
        UI_HOME,
        UI_ENTER,
        UI_SAVE,
        UI_SHOW
    } t_ui_mode;

    typedef enum logic [1:0] {
        BTN_STANDBY,
        BTN_CHECK,
        BTN_CLEAR
    } t_btn_mode;

    typedef struct packed {
        logic [2:0] pin_length;
        logic [7:0] display_ticks;
        logic [7:0] unlock_ticks;
        logic [4:0] hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic       button_pressed;
        logic [3:0] key_code;
        logic       key_valid;
    } t_key_beat;

    typedef struct packed {
        logic              valid;
        t_key_beat         beat;
    } t_in_slot;

    typedef struct packed {
        logic [SCNT_W-1:0] pins_saved;
        logic [2:0]        keys_entered;
        logic [2:0]        screen;
        logic              buzzer_on;
        logic              door_unlocked;
    } t_result;

endpackage

@@ rtl/core/kplc_in_stage.sv @@
// ----------------------------------------------------------------------------
// kplc_in_stage
// Input register for key beats; refills in the cycle the held beat is taken.
// ----------------------------------------------------------------------------
module kplc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  kplc_pkg::t_key_beat i_beat,
    input  logic                i_take,
    output kplc_pkg::t_in_slot  o_slot
);
    import kplc_pkg::*;

    logic      r_valid;
    t_key_beat r_beat;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= i_beat;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.beat  = r_beat;

endmodule

@@ rtl/core/kplc_step.sv @@
// ----------------------------------------------------------------------------
// kplc_step
// Lock state: UI, lock and button-hold machines plus PIN slot store.
// Steps once per taken beat; result reflects state after the step.
// ----------------------------------------------------------------------------
module kplc_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  kplc_pkg::t_key_beat i_beat,
    input  kplc_pkg::t_cfg      i_cfg,
    output kplc_pkg::t_result   o_res
);
    import kplc_pkg::*;

    t_ui_mode            r_ui, n_ui;
    t_btn_mode           r_btn, n_btn;
    logic                r_lock, n_lock;
    logic                r_phase;
    logic [7:0]          r_ecnt, n_ecnt;
    logic [7:0]          r_ucnt, n_ucnt;
    logic [4:0]          r_hcnt, n_hcnt;
    logic [ENTRY_W-1:0]  r_ebuf, n_ebuf;
    logic [ENTRY_W-1:0]  r_slots [PIN_SLOTS];
    logic [ENTRY_W-1:0]  n_slots [PIN_SLOTS];
    logic [PIN_SLOTS-1:0] r_sval, n_sval;
    logic [SCNT_W-1:0]   r_scnt, n_scnt;
    logic                r_acc, n_acc;
    logic                r_clr, n_clr;
    logic [2:0]          r_scr, n_scr;

    logic [2:0] len;
    logic       hit;

    // length register clamped to 1..MAX_PIN_KEYS
    always_comb begin
        if (i_cfg.pin_length == 3'd0) begin
            len = 3'd1;
        end else if (i_cfg.pin_length > 3'(MAX_PIN_KEYS)) begin
            len = 3'(MAX_PIN_KEYS);
        end else begin
            len = i_cfg.pin_length;
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int s = 0; s < PIN_SLOTS; s++) begin
            if (r_sval[s] && (r_slots[s] == r_ebuf)) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        logic key_used;
        logic placed;
        logic kv;
        logic b;
        kv       = i_beat.key_valid;
        b        = i_beat.button_pressed;
        key_used = 1'b0;
        placed   = 1'b0;
        n_ui     = r_ui;
        n_btn    = r_btn;
        n_lock   = r_lock;
        n_ecnt   = r_ecnt;
        n_ucnt   = r_ucnt;
        n_hcnt   = r_hcnt;
        n_ebuf   = r_ebuf;
        n_slots  = r_slots;
        n_sval   = r_sval;
        n_scnt   = r_scnt;
        n_acc    = r_acc;
        n_clr    = r_clr;
        n_scr    = r_scr;

        // UI machine, slow ticks only
        if (r_phase) begin
            unique case (r_ui)
                UI_HOME: begin
                    key_used = 1'b1;
                    if (kv && i_beat.key_code == KEY_HASH) begin
                        n_ui = UI_ENTER; n_scr = SCR_ENTER; n_ecnt = '0; n_ebuf = '0;
                    end else if (kv && i_beat.key_code == KEY_ADD) begin
                        n_ui = UI_SAVE; n_scr = SCR_ADD; n_ecnt = '0; n_ebuf = '0;
                    end else if (r_clr) begin
                        n_ui = UI_SHOW; n_scr = SCR_RESET; n_ecnt = '0;
                    end
                end
                UI_ENTER: begin
                    if (r_ecnt >= {5'd0, len}) begin
                        n_acc = hit;
                        n_scr = hit ? SCR_UNLOCKED : SCR_INCORRECT;
                        n_ui  = UI_SHOW; n_ecnt = '0; n_ebuf = '0;
                    end
                end
                UI_SAVE: begin
                    if (r_scnt >= SCNT_W'(PIN_SLOTS)) begin
                        n_ui = UI_SHOW; n_scr = SCR_MAX_PINS; n_ecnt = '0; n_ebuf = '0;
                    end else if (r_ecnt >= {5'd0, len}) begin
                        // lowest free slot takes the new PIN
                        for (int s = 0; s < PIN_SLOTS; s++) begin
                            if (!placed && !r_sval[s]) begin
                                n_slots[s] = r_ebuf;
                                n_sval[s]  = 1'b1;
                                placed     = 1'b1;
                            end
                        end
                        n_scnt = r_scnt + SCNT_W'(1);
                        n_ui = UI_SHOW; n_scr = SCR_SAVED; n_ecnt = '0; n_ebuf = '0;
                    end
                end
                UI_SHOW: begin
                    if (!r_acc && r_ecnt > i_cfg.display_ticks) begin
                        n_ui = UI_HOME; n_scr = SCR_HOME;
                    end
                end
                default: begin
                    n_ui = UI_HOME; n_scr = SCR_HOME;
                end
            endcase

            if (n_ui == UI_ENTER || n_ui == UI_SAVE) begin
                if (!key_used && kv && n_ecnt < {5'd0, len}) begin
                    for (int k = 0; k < MAX_PIN_KEYS; k++) begin
                        if (n_ecnt == 8'(k)) begin
                            n_ebuf[4*k +: 4] = n_ebuf[4*k +: 4] | i_beat.key_code;
                        end
                    end
                    n_ecnt = n_ecnt + 8'd1;
                end
            end else if (n_ui == UI_SHOW) begin
                if (n_ecnt < ECNT_MAX) begin
                    n_ecnt = n_ecnt + 8'd1;
                end
            end
        end

        // lock machine, every tick
        if (!n_lock) begin
            if (n_acc) begin
                n_lock = 1'b1;
            end
        end else if (n_ucnt > i_cfg.unlock_ticks) begin
            n_lock = 1'b0; n_acc = 1'b0; n_ucnt = '0;
        end
        if (n_lock && n_ucnt < UCNT_MAX) begin
            n_ucnt = n_ucnt + 8'd1;
        end

        // button-hold machine, slow ticks only
        if (r_phase) begin
            unique case (r_btn)
                BTN_STANDBY: begin
                    if (b && n_scnt != '0) begin
                        n_btn = BTN_CHECK;
                    end
                end
                BTN_CHECK: begin
                    if (b && r_hcnt < i_cfg.hold_ticks) begin
                        n_btn = BTN_CHECK;
                    end else if (r_hcnt > i_cfg.hold_ticks) begin
                        n_clr = 1'b1; n_btn = BTN_CLEAR; n_hcnt = '0;
                    end else if (!b) begin
                        n_btn = BTN_STANDBY; n_hcnt = '0;
                    end
                end
                BTN_CLEAR: begin
                    if (r_hcnt >= 5'(PIN_SLOTS)) begin
                        n_btn = BTN_STANDBY; n_clr = 1'b0; n_hcnt = '0;
                    end
                end
                default: begin
                    n_btn = BTN_STANDBY;
                end
            endcase

            if (n_btn == BTN_CHECK) begin
                if (b && n_hcnt < HCNT_MAX) begin
                    n_hcnt = n_hcnt + 5'd1;
                end
            end else if (n_btn == BTN_CLEAR) begin
                // invalid slots are never compared, so only valid bits drop
                n_sval = '0;
                n_scnt = '0;
                if (n_hcnt < HCNT_MAX) begin
                    n_hcnt = n_hcnt + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ui    <= UI_HOME;
            r_btn   <= BTN_STANDBY;
            r_lock  <= 1'b0;
            r_phase <= 1'b0;
            r_ecnt  <= '0;
            r_ucnt  <= '0;
            r_hcnt  <= '0;
            r_ebuf  <= '0;
            r_sval  <= '0;
            r_scnt  <= '0;
            r_acc   <= 1'b0;
            r_clr   <= 1'b0;
            r_scr   <= SCR_HOME;
        end else if (i_adv) begin
            r_ui    <= n_ui;
            r_btn   <= n_btn;
            r_lock  <= n_lock;
            r_phase <= !r_phase;
            r_ecnt  <= n_ecnt;
            r_ucnt  <= n_ucnt;
            r_hcnt  <= n_hcnt;
            r_ebuf  <= n_ebuf;
            r_sval  <= n_sval;
            r_scnt  <= n_scnt;
            r_acc   <= n_acc;
            r_clr   <= n_clr;
            r_scr   <= n_scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_slots <= n_slots;
        end
    end

    assign o_res.door_unlocked = n_lock;
    assign o_res.buzzer_on     = n_lock;
    assign o_res.screen        = n_scr;
    assign o_res.keys_entered  = (n_ui == UI_ENTER || n_ui == UI_SAVE) ? n_ecnt[2:0] : 3'd0;
    assign o_res.pins_saved    = n_scnt;

`ifndef SYNTH
    a_locked_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lock |-> r_ucnt == '0)
        else $error("unlock counter running while locked");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_sval) == 32'(r_scnt))
        else $error("slot count differs from valid bits");

    a_clear_req_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_btn == BTN_CLEAR) == r_clr)
        else $error("clear request out of step with button machine");

    a_unlock_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> r_acc)
        else $error("door unlocked without accepted PIN");
`endif

endmodule

@@ rtl/core/keypad_pin_lock_controller.sv @@
// ----------------------------------------------------------------------------
// keypad_pin_lock_controller
// Keypad PIN lock: one 50 ms tick per input beat, one status beat out per tick.
//
//   channel   dir  tdata bits (low first)
//   s_axis    in   key_valid[0] key_code[4:1] button_pressed[5], pad to 8
//   m_axis    out  door_unlocked[0] buzzer_on[1] screen[4:2]
//                  keys_entered[7:5] pins_saved[9:8], pad to 16
//   cfg       in   i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// One tick per clock sustained while the output is not stalled; an input beat
// passes the input register, then the state step into the output register.
// The state step is a combinational pass over the UI, lock and button logic.
// Reset is synchronous, active low; control registers reset, but PIN slots and beat data do not.
// A stalled output holds its beat and backs up the input register.
// ----------------------------------------------------------------------------
module keypad_pin_lock_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // key_valid, key_code[3:0], button_pressed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // door_unlocked, buzzer_on, screen[2:0],
                                        // keys_entered[2:0], pins_saved[1:0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import kplc_pkg::*;

    t_cfg      r_cfg;
    t_in_slot  in_slot;
    t_key_beat in_beat;
    t_result   step_res;
    t_result   r_out;
    logic      r_out_valid;
    logic      adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_length    <= 3'd5;
            r_cfg.display_ticks <= 8'd30;
            r_cfg.unlock_ticks  <= 8'd120;
            r_cfg.hold_ticks    <= 5'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PIN_LENGTH:    r_cfg.pin_length    <= i_cfg_wdata[2:0];
                CFG_DISPLAY_TICKS: r_cfg.display_ticks <= i_cfg_wdata;
                CFG_UNLOCK_TICKS:  r_cfg.unlock_ticks  <= i_cfg_wdata;
                CFG_HOLD_TICKS:    r_cfg.hold_ticks    <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    assign in_beat.key_valid      = s_axis_tdata[0];
    assign in_beat.key_code       = s_axis_tdata[4:1];
    assign in_beat.button_pressed = s_axis_tdata[5];

    assign adv = in_slot.valid && (!r_out_valid || m_axis_tready);

    kplc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (in_beat),
        .i_take  (adv),
        .o_slot  (in_slot)
    );

    kplc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_beat  (in_slot.beat),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule
